/* sv/prs_pkg.sv */
package prs_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 19;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_SIZE = 1'b1;

    // request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_ACCESS = 1'b1;

    // defaults and fixed limits
    localparam int MAX_PAGES_DEF      = 64;
    localparam int MAX_PAGE_SIZE_DEF  = 4096;
    localparam int PHYS_PAGE_BITS_DEF = 16;
    localparam int MAX_RESULTS        = 64;
    localparam int PAGE_IDX_W         = 12;   // holds any index below the largest table
    localparam int JOB_QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  entry_index;
        logic [15:0] phys_page;
        logic [17:0] start_pos;
        logic [18:0] length;
        logic        is_write;
    } t_req;

    typedef struct packed {
        logic        status;
        logic        seg_valid;
        logic [15:0] seg_phys_page;
        logic [11:0] seg_offset;
        logic [12:0] seg_length;
        logic [17:0] buffer_offset;
        logic        seg_write;
        logic        last;
    } t_res;

    typedef enum logic [1:0] {
        JOB_LOAD,
        JOB_SPLIT,
        JOB_REJECT,
        JOB_EMPTY
    } t_job_kind;

    // work handed from the classifier to the segment engine
    typedef struct packed {
        t_job_kind             kind;
        logic [PAGE_IDX_W-1:0] idx;
        logic [15:0]           phys;
        logic [12:0]           pos;
        logic [18:0]           len;
        logic [12:0]           ps;
        logic                  wr;
    } t_job;

endpackage

/* sv/prs_front.sv */
module prs_front #(
    parameter int MAX_PAGES     = prs_pkg::MAX_PAGES_DEF,
    parameter int MAX_PAGE_SIZE = prs_pkg::MAX_PAGE_SIZE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  prs_pkg::t_req                    i_req,
    input  logic                             i_cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_full,
    output logic                             o_push,
    output prs_pkg::t_job                    o_job
);
    import prs_pkg::*;

    localparam int DIV_W     = 20;
    localparam int DIV_STEPS = DIV_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_PUSH
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [12:0] r_pg_bytes;
    logic [18:0] r_item_size;
    logic [DIV_W-1:0] r_div_a;
    logic [DIV_W-1:0] r_div_b;
    logic [12:0] r_rem_a;
    logic [12:0] r_rem_b;
    logic [12:0] r_ps;
    logic [4:0]  r_cnt;

    logic [12:0]      ps_eff;
    logic [DIV_W-1:0] end_sum;
    logic             over_size;
    logic             entry_ok;
    logic [13:0]      sh_a;
    logic [13:0]      sh_b;
    logic             ge_a;
    logic             ge_b;
    logic [13:0]      n_rem_a;
    logic [13:0]      n_rem_b;
    logic [DIV_W-1:0] span;
    logic             reject;

    always_comb begin
        ps_eff = (r_pg_bytes == 13'd0) ? 13'd1 : r_pg_bytes;
        if (17'(ps_eff) > 17'(MAX_PAGE_SIZE)) begin
            ps_eff = 13'(MAX_PAGE_SIZE);
        end
    end

    assign end_sum   = DIV_W'(i_req.start_pos) + DIV_W'(i_req.length);
    assign over_size = end_sum > DIV_W'(r_item_size);
    assign entry_ok  = 13'(i_req.entry_index) < 13'(MAX_PAGES);

    // restoring division, both dividends one bit a cycle against the same page size
    assign sh_a    = {r_rem_a, r_div_a[DIV_W-1]};
    assign sh_b    = {r_rem_b, r_div_b[DIV_W-1]};
    assign ge_a    = sh_a >= {1'b0, r_ps};
    assign ge_b    = sh_b >= {1'b0, r_ps};
    assign n_rem_a = ge_a ? sh_a - {1'b0, r_ps} : sh_a;
    assign n_rem_b = ge_b ? sh_b - {1'b0, r_ps} : sh_b;

    // quotients: a = first page, b = last page
    assign span   = r_div_b - r_div_a;
    assign reject = (r_div_b >= DIV_W'(MAX_PAGES)) || (span >= DIV_W'(MAX_RESULTS));

    assign busy   = r_state != S_IDLE;
    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_job  = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg_bytes  <= 13'd4096;
            r_item_size <= 19'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAGE_SIZE: r_pg_bytes  <= i_cfg_data[12:0];
                CFG_ITEM_SIZE: r_item_size <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_job.wr   <= i_req.is_write;
                        r_job.ps   <= ps_eff;
                        r_job.len  <= i_req.length;
                        r_job.phys <= i_req.phys_page;
                        r_job.idx  <= PAGE_IDX_W'(i_req.entry_index);
                        r_job.pos  <= 13'd0;
                        priority if (i_req.req_type == REQ_LOAD) begin
                            r_job.kind <= JOB_LOAD;
                            if (entry_ok) begin
                                r_state <= S_PUSH;
                            end
                        end else if (over_size) begin
                            r_job.kind <= JOB_REJECT;
                            r_state    <= S_PUSH;
                        end else if (i_req.length == 19'd0) begin
                            r_job.kind <= JOB_EMPTY;
                            r_state    <= S_PUSH;
                        end else begin
                            r_ps    <= ps_eff;
                            r_div_a <= DIV_W'(i_req.start_pos);
                            r_div_b <= end_sum - DIV_W'(1);
                            r_rem_a <= 13'd0;
                            r_rem_b <= 13'd0;
                            r_cnt   <= 5'd0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem_a <= n_rem_a[12:0];
                    r_rem_b <= n_rem_b[12:0];
                    r_div_a <= {r_div_a[DIV_W-2:0], ge_a};
                    r_div_b <= {r_div_b[DIV_W-2:0], ge_b};
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_job.kind <= reject ? JOB_REJECT : JOB_SPLIT;
                    r_job.idx  <= r_div_a[PAGE_IDX_W-1:0];
                    r_job.pos  <= r_rem_a;
                    r_state    <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

/* sv/prs_queue.sv */
module prs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  prs_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output prs_pkg::t_job o_head
);
    import prs_pkg::*;

    localparam int PW = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(JOB_QUEUE_DEPTH + 1);

    t_job          r_mem [JOB_QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == CW'(JOB_QUEUE_DEPTH);
    assign o_empty = r_count == CW'(0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* sv/prs_back.sv */
module prs_back #(
    parameter int MAX_PAGES      = prs_pkg::MAX_PAGES_DEF,
    parameter int PHYS_PAGE_BITS = prs_pkg::PHYS_PAGE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  prs_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_strobe,
    output prs_pkg::t_res o_res
);
    import prs_pkg::*;

    localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    typedef enum logic {
        B_IDLE,
        B_SEG
    } t_state;

    logic [PHYS_PAGE_BITS-1:0] r_table [MAX_PAGES];
    logic [PHYS_PAGE_BITS-1:0] r_rd_data;

    t_state                r_state;
    logic                  r_strobe;
    t_res                  r_res;
    logic [PAGE_IDX_W-1:0] r_idx;
    logic [12:0]           r_pos;
    logic [18:0]           r_rem;
    logic [18:0]           r_buf;
    logic [12:0]           r_ps;
    logic                  r_wr;

    logic                      pop;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [PHYS_PAGE_BITS-1:0] wr_data;
    logic [31:0]               phys_ext;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [PAGE_IDX_W-1:0]     next_idx;
    logic [31:0]               rd_ext;
    logic [19:0]               pos_sum;
    logic [12:0]               seg;
    logic                      seg_last;

    assign pop      = (r_state == B_IDLE) && !i_empty;
    assign o_pop    = pop;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    assign phys_ext = 32'(i_job.phys);
    assign wr_en    = pop && (i_job.kind == JOB_LOAD);
    assign wr_addr  = i_job.idx[AW-1:0];
    assign wr_data  = phys_ext[PHYS_PAGE_BITS-1:0];

    // segment split: stop at the page end or at the end of the request
    assign pos_sum  = 20'(r_pos) + 20'(r_rem);
    assign seg      = (pos_sum > 20'(r_ps)) ? r_ps - r_pos : r_rem[12:0];
    assign seg_last = 19'(seg) == r_rem;
    assign next_idx = r_idx + PAGE_IDX_W'(1);
    assign rd_ext   = 32'(r_rd_data);

    // table read runs one page ahead of the segment on the output
    always_comb begin
        if (r_state == B_SEG) begin
            rd_en   = !seg_last;
            rd_addr = next_idx[AW-1:0];
        end else begin
            rd_en   = pop && (i_job.kind == JOB_SPLIT);
            rd_addr = i_job.idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_strobe <= 1'b0;
        end else begin
            // a segment goes out every cycle in B_SEG; reject and empty give one result
            r_strobe <= (r_state == B_SEG) ||
                        (pop && ((i_job.kind == JOB_REJECT) || (i_job.kind == JOB_EMPTY)));
            unique case (r_state)
                B_IDLE: begin
                    if (pop) begin
                        unique case (i_job.kind)
                            JOB_LOAD: begin
                            end
                            JOB_SPLIT: begin
                                r_idx   <= i_job.idx;
                                r_pos   <= i_job.pos;
                                r_rem   <= i_job.len;
                                r_buf   <= 19'd0;
                                r_ps    <= i_job.ps;
                                r_wr    <= i_job.wr;
                                r_state <= B_SEG;
                            end
                            JOB_REJECT, JOB_EMPTY: begin
                                r_res.status        <= i_job.kind == JOB_REJECT;
                                r_res.seg_valid     <= 1'b0;
                                r_res.seg_phys_page <= 16'd0;
                                r_res.seg_offset    <= 12'd0;
                                r_res.seg_length    <= 13'd0;
                                r_res.buffer_offset <= 18'd0;
                                r_res.seg_write     <= i_job.wr;
                                r_res.last          <= 1'b1;
                            end
                        endcase
                    end
                end
                B_SEG: begin
                    r_res.status        <= 1'b0;
                    r_res.seg_valid     <= 1'b1;
                    r_res.seg_phys_page <= rd_ext[15:0];
                    r_res.seg_offset    <= r_pos[11:0];
                    r_res.seg_length    <= seg;
                    r_res.buffer_offset <= r_buf[17:0];
                    r_res.seg_write     <= r_wr;
                    r_res.last          <= seg_last;
                    r_pos               <= 13'd0;
                    r_rem               <= r_rem - 19'(seg);
                    r_buf               <= r_buf + 19'(seg);
                    r_idx               <= next_idx;
                    if (seg_last) begin
                        r_state <= B_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

/* sv/paged_request_splitter.sv */
// Paged request splitter.
// Requests enter on i_req with start; one is taken at a clock edge where start
// is high and busy is low. A load request writes one page table entry and
// gives no result. An access request is checked against item_size and the
// table, then split at page boundaries; each result appears on o_res for one
// cycle with o_strobe high, the last one carrying last = 1. A failed check or
// a zero-length access gives a single result.
// The classifier holds busy after a load or a rejected/empty access until its
// job enters the queue, and after an access that is split also while the page
// index and offset come from a bit-serial divider that works through the
// 20-bit start and last-byte addresses; a new request waits for that job.
// A two-entry queue sits between classifier and segment engine, so the next
// request is classified while segments still go out. The segment engine
// gives one segment per cycle once the table read for the first page is
// registered.
// Reset empties the queue, returns both units to idle and sets the page length
// to 4096 bytes and item_size to 0; table entries hold nothing until loaded.
// The receiver cannot stall: results are taken in the cycle they appear.
module paged_request_splitter #(
    parameter int MAX_PAGES      = prs_pkg::MAX_PAGES_DEF,
    parameter int MAX_PAGE_SIZE  = prs_pkg::MAX_PAGE_SIZE_DEF,
    parameter int PHYS_PAGE_BITS = prs_pkg::PHYS_PAGE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  prs_pkg::t_req                  i_req,
    output logic                           o_strobe,
    output prs_pkg::t_res                  o_res,
    input  logic                           i_cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import prs_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job job_in;
    t_job job_head;

    prs_front #(
        .MAX_PAGES     (MAX_PAGES),
        .MAX_PAGE_SIZE (MAX_PAGE_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job_in)
    );

    prs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (job_head)
    );

    prs_back #(
        .MAX_PAGES      (MAX_PAGES),
        .PHYS_PAGE_BITS (PHYS_PAGE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_job    (job_head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

/* tb/sv/paged_request_splitter_tb.sv */
module paged_request_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prs_pkg::*;

    localparam int unsigned START_MAX   = 262143;
    localparam int unsigned LEN_MAX     = 524287;
    localparam int unsigned DRAIN_CYC   = 48;     // covers a trailing load in the pipeline
    localparam int unsigned SETTLE_MAX  = 100000;
    localparam int unsigned PRINT_LIMIT = 40;

    typedef enum {ACC_REJECT, ACC_EMPTY, ACC_SPLIT} t_acc_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    logic                  o_strobe;
    t_res                  o_res;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_req        pending[$];
    t_res        expected_segs[$];
    logic [15:0] page_map [MAX_PAGES_DEF];
    bit          gen_loaded [MAX_PAGES_DEF];
    int unsigned pg_size_cfg = 4096;
    int unsigned item_size_cfg = 0;
    int unsigned send_idle_pct = 16;
    bit          req_taken = 1'b0;
    int unsigned errors = 0;
    int unsigned n_loads = 0;
    int unsigned n_accesses = 0;
    int unsigned n_segs = 0;
    int unsigned n_rejects = 0;
    int unsigned n_empty = 0;
    int unsigned n_settings = 1;

    paged_request_splitter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // zero is taken as one byte, anything above the largest page is clipped
    function automatic int unsigned eff_page_size();
        if (pg_size_cfg == 0) return 1;
        if (pg_size_cfg > MAX_PAGE_SIZE_DEF) return MAX_PAGE_SIZE_DEF;
        return pg_size_cfg;
    endfunction

    function automatic t_acc_kind classify_access(input int unsigned st, input int unsigned ln,
                                                  output int unsigned first_pg,
                                                  output int unsigned last_pg);
        int unsigned ps;
        ps = eff_page_size();
        first_pg = 0;
        last_pg = 0;
        if (st + ln > item_size_cfg) return ACC_REJECT;
        if (ln == 0) return ACC_EMPTY;
        first_pg = st / ps;
        last_pg = (st + ln - 1) / ps;
        if (last_pg >= MAX_PAGES_DEF || last_pg - first_pg + 1 > MAX_RESULTS) return ACC_REJECT;
        return ACC_SPLIT;
    endfunction

    task automatic split_request(input t_req r);
        t_res        res;
        t_acc_kind   kind;
        int unsigned ps, first_pg, last_pg, pos, rem, seg, buf_off, pg;
        if (r.req_type == REQ_LOAD) begin
            page_map[r.entry_index] = r.phys_page;
            n_loads++;
            return;
        end
        n_accesses++;
        ps = eff_page_size();
        kind = classify_access(32'(r.start_pos), 32'(r.length), first_pg, last_pg);
        res = '0;
        res.seg_write = r.is_write;
        if (kind != ACC_SPLIT) begin
            res.status = (kind == ACC_REJECT);
            res.last = 1'b1;
            expected_segs.push_back(res);
            if (kind == ACC_REJECT) n_rejects++;
            else n_empty++;
            return;
        end
        pos = 32'(r.start_pos) % ps;
        rem = 32'(r.length);
        buf_off = 0;
        pg = first_pg;
        while (rem > 0) begin
            seg = (pos + rem > ps) ? ps - pos : rem;
            res.seg_valid = 1'b1;
            res.seg_phys_page = page_map[pg];
            res.seg_offset = 12'(pos);
            res.seg_length = 13'(seg);
            res.buffer_offset = 18'(buf_off);
            res.last = (seg == rem);
            expected_segs.push_back(res);
            n_segs++;
            pg++;
            buf_off += seg;
            pos = 0;
            rem -= seg;
        end
    endtask

    task automatic compare_field(input string nm, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, exp_v, act_v);
        end
    endtask

    task automatic push_load(input int unsigned entry, input int unsigned phys);
        t_req r;
        r.start_pos = 18'($urandom);
        r.length = 19'($urandom);
        r.is_write = 1'($urandom);
        r.req_type = REQ_LOAD;
        r.entry_index = 6'(entry);
        r.phys_page = 16'(phys);
        pending.push_back(r);
        gen_loaded[entry] = 1'b1;
    endtask

    // any page the access will read gets a load queued ahead of it
    task automatic push_access(input int unsigned st, input int unsigned ln, input bit wr);
        t_req        r;
        t_acc_kind   kind;
        int unsigned first_pg, last_pg, i;
        kind = classify_access(st, ln, first_pg, last_pg);
        if (kind == ACC_SPLIT) begin
            for (i = first_pg; i <= last_pg; i++)
                if (!gen_loaded[i]) push_load(i, $urandom_range(0, 65535));
        end
        r.req_type = REQ_ACCESS;
        r.entry_index = 6'($urandom);
        r.phys_page = 16'($urandom);
        r.start_pos = 18'(st);
        r.length = 19'(ln);
        r.is_write = wr;
        pending.push_back(r);
    endtask

    task automatic add_random_requests(input int unsigned count);
        int unsigned ps, span, st, cap, roll, n;
        bit          wr;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            wr = 1'($urandom_range(0, 1));
            ps = eff_page_size();
            span = item_size_cfg;
            if (span > MAX_PAGES_DEF * ps) span = MAX_PAGES_DEF * ps;
            if (roll < 25) begin
                push_load($urandom_range(0, MAX_PAGES_DEF - 1), $urandom_range(0, 65535));
            end else if (roll < 85) begin
                // well-formed: ends inside both the item and the table
                if (span == 0) begin
                    push_access(0, 0, wr);
                end else begin
                    st = $urandom_range(0, span - 1);
                    cap = span - st;
                    if ($urandom_range(0, 3) != 0 && cap > 3 * ps) cap = 3 * ps;
                    push_access(st, $urandom_range(1, cap), wr);
                end
            end else if (roll < 92) begin
                st = $urandom_range(0, item_size_cfg + 1);
                if (st > START_MAX) st = START_MAX;
                push_access(st, 0, wr);
            end else begin
                push_access($urandom_range(0, START_MAX), $urandom_range(0, LEN_MAX), wr);
            end
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PAGE_SIZE) pg_size_cfg = data & 32'h1FFF;
        else item_size_cfg = data & 32'h7FFFF;
    endtask

    task automatic settle_block();
        int unsigned guard;
        guard = 0;
        while ((pending.size() != 0 || start || expected_segs.size() != 0)
               && guard < SETTLE_MAX) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= SETTLE_MAX) begin
            errors++;
            $display("%0t: block stalled, %0d requests queued, %0d results outstanding",
                     $time, pending.size(), expected_segs.size());
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic next_setting(input int unsigned ps, input int unsigned isz,
                                input int unsigned idle);
        settle_block();
        write_cfg(CFG_PAGE_SIZE, ps);
        write_cfg(CFG_ITEM_SIZE, isz);
        send_idle_pct = idle;
        n_settings++;
    endtask

    // request accepted on this edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            split_request(i_req);
            req_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            req_taken = 1'b0;
        end else if (!start || req_taken) begin
            req_taken = 1'b0;
            if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_req <= pending.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_strobe) begin
            if (expected_segs.size() == 0) begin
                errors++;
                if (errors <= PRINT_LIMIT)
                    $display("%0t: unexpected result, expected none, got %p", $time, o_res);
            end else begin
                exp_r = expected_segs.pop_front();
                compare_field("status", 32'(exp_r.status), 32'(o_res.status));
                compare_field("seg_valid", 32'(exp_r.seg_valid), 32'(o_res.seg_valid));
                compare_field("seg_phys_page", 32'(exp_r.seg_phys_page),
                              32'(o_res.seg_phys_page));
                compare_field("seg_offset", 32'(exp_r.seg_offset), 32'(o_res.seg_offset));
                compare_field("seg_length", 32'(exp_r.seg_length), 32'(o_res.seg_length));
                compare_field("buffer_offset", 32'(exp_r.buffer_offset),
                              32'(o_res.buffer_offset));
                compare_field("seg_write", 32'(exp_r.seg_write), 32'(o_res.seg_write));
                compare_field("last", 32'(exp_r.last), 32'(o_res.last));
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: item size zero, so nothing can be split
        push_access(0, 0, 1'b0);
        push_access(0, 1, 1'b1);
        push_access(5, 0, 1'b0);

        next_setting(MAX_PAGE_SIZE_DEF, 262144, 16);
        push_load(0, 'h0000);
        push_load(MAX_PAGES_DEF - 1, 'hFFFF);
        push_load(1, 'h5A5A);
        push_access(0, 0, 1'b0);
        push_access(START_MAX, 0, 1'b1);
        push_access(0, 1, 1'b0);
        push_access(4095, 2, 1'b1);
        push_access(START_MAX, 1, 1'b0);
        push_access(START_MAX, 2, 1'b1);
        push_access(0, LEN_MAX, 1'b0);
        push_access(63 * 4096, 4096, 1'b1);
        push_access(0, 4096, 1'b0);
        add_random_requests(8);

        // one-byte pages: index 64 lies past the table
        next_setting(1, 262144, 16);
        push_access(63, 1, 1'b0);
        push_access(64, 1, 1'b1);
        add_random_requests(8);

        // page size zero behaves as one byte; full table span
        next_setting(0, 100, 67);
        push_access(0, 64, 1'b1);
        push_access(64, 1, 1'b0);
        add_random_requests(8);

        // oversized page is clipped to the largest page
        next_setting(8191, 200000, 67);
        push_access(4095, 2, 1'b1);
        add_random_requests(8);

        next_setting($urandom_range(2, 4095), $urandom_range(1, 262144), 0);
        add_random_requests(10);

        next_setting(MAX_PAGE_SIZE_DEF, 262144, 0);
        push_access(0, 262144, 1'b1);
        add_random_requests(8);

        settle_block();
        if (expected_segs.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_segs.size());
        end
        $display("covered %0d table loads and %0d accesses over %0d register settings",
                 n_loads, n_accesses, n_settings);
        $display("predicted %0d segments, %0d rejected and %0d empty accesses",
                 n_segs, n_rejects, n_empty);
        if (errors == 0) begin
            $display("paged_request_splitter_tb passed");
        end else begin
            $display("paged_request_splitter_tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("paged_request_splitter_tb failed");
        $finish;
    end

endmodule

/* files.f */
sv/prs_pkg.sv
sv/prs_front.sv
sv/prs_queue.sv
sv/prs_back.sv
sv/paged_request_splitter.sv
tb/sv/paged_request_splitter_tb.sv
